[src/rqps_pkg.sv]
// Shared types, widths and codes of the ready queue policy scheduler.
`default_nettype none
package rqps_pkg;

  // Field widths
  localparam int ACTION_W = 1;
  localparam int PROC_W   = 8;
  localparam int BURST_W  = 24;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;

  // Ready table depth default
  localparam int DEPTH_DEF = 16;

  // Configuration port geometry
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index (paddr[2] selects the register word)
  localparam logic REG_POLICY = 1'b0;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_SELECT = 1'b1;

  // Policies; the unused code behaves as oldest first
  localparam logic [POLICY_W-1:0] POL_OLDEST   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LOW_ID   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SHORTEST = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // One ready table entry
  typedef struct packed {
    logic [PROC_W-1:0]  proc;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage
`default_nettype wire

[src/rqps_in_if.sv]
// Input channel of the scheduler: insert or select transactions.
`default_nettype none
interface rqps_in_if import rqps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PROC_W-1:0]   proc_id;
  logic [BURST_W-1:0]  burst_left;

  modport source (output valid, action, proc_id, burst_left, input ready);
  modport sink   (input valid, action, proc_id, burst_left, output ready);
endinterface
`default_nettype wire

[src/rqps_out_if.sv]
// Result channel of the scheduler: selected entry and status.
`default_nettype none
interface rqps_out_if import rqps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PROC_W-1:0]   out_proc_id;
  logic [BURST_W-1:0]  out_burst;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_proc_id, out_burst, status, input ready);
  modport sink   (input valid, out_proc_id, out_burst, status, output ready);
endinterface
`default_nettype wire

[src/rqps_mem.sv]
// Ready table storage: one write port, one registered read port.
`default_nettype none
module rqps_mem import rqps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/rqps_cmp.sv]
// Shared key compare: is the candidate entry preferred over the current best.
`default_nettype none
module rqps_cmp import rqps_pkg::*; (
  input  wire logic [POLICY_W-1:0] policy,
  input  wire entry_t              cand,
  input  wire entry_t              best,
  output logic                     better
);

  logic [BURST_W-1:0] key_cand;
  logic [BURST_W-1:0] key_best;
  logic               keyed;

  // Pick the key the policy orders by
  always_comb begin
    key_cand = cand.burst;
    key_best = best.burst;
    keyed    = 1'b0;
    case (policy)
      POL_LOW_ID: begin
        key_cand = BURST_W'(cand.proc);
        key_best = BURST_W'(best.proc);
        keyed    = 1'b1;
      end
      POL_SHORTEST: begin
        keyed = 1'b1;
      end
      default: begin
        keyed = 1'b0;
      end
    endcase
  end

  // Strictly less keeps the earliest entry on ties
  assign better = keyed && (key_cand < key_best);

endmodule
`default_nettype wire

[src/ready_queue_policy_scheduler.sv]
// Top level of the ready queue policy scheduler: sequencer, table and config port.
//
// Keeps up to DEPTH ready entries in arrival order in a single-port-read table.
// An insert transaction is written to the table when it is accepted, and its
// result then goes to the output register. A select on a table of N entries
// scans all N entries through one shared comparator, one entry per cycle, then
// closes the gap left by the chosen entry at index k by moving the N-1-k
// younger entries down one slot per cycle, and presents the result through
// the output register. Empty selects and inserts, refused ones too, skip the
// scan and the shift and go straight to presenting their result. One
// transaction is in work at a time; the input is ready only while the
// sequencer is idle, and a finished result waits in the output register while
// the next one is accepted. No clearing pass is needed after reset. The policy
// register sits at byte address 0; the user must write it only while the block
// is idle, and the block itself does not enforce this.
`default_nettype none
module ready_queue_policy_scheduler import rqps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rqps_in_if.sink                in_ch,
  rqps_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic                dv_r, dv_nxt;
  logic [IW-1:0]       didx_r, didx_nxt;
  entry_t              best_r, best_nxt;
  logic [IW-1:0]       bidx_r, bidx_nxt;
  entry_t              res_r, res_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic [POLICY_W-1:0] policy_r;
  logic                out_valid_r;
  entry_t              out_data_r;
  logic [STATUS_W-1:0] out_stat_r;

  logic                in_fire;
  logic                issue;
  logic                better;
  logic                take;
  logic                last_data;
  logic [IW-1:0]       bidx_sel;
  logic                out_load;
  logic                cfg_wr;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  entry_t              mem_rdata;
  entry_t              in_entry;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_POLICY);
  assign cfg_prdata = (cfg_paddr[2] == REG_POLICY) ? CFG_DW'(policy_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_OLDEST;
    end else if (cfg_wr) begin
      policy_r <= cfg_pwdata[POLICY_W-1:0];
    end
  end

  // Handshake and read issue
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_entry    = '{proc: in_ch.proc_id, burst: in_ch.burst_left};
  assign issue       = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (ptr_r < count_r);

  rqps_cmp u_cmp (
    .policy (policy_r),
    .cand   (mem_rdata),
    .best   (best_r),
    .better (better)
  );

  assign take      = dv_r && ((didx_r == '0) || better);
  assign last_data = dv_r && (CW'(didx_r) == (count_r - CW'(1)));
  assign bidx_sel  = take ? didx_r : bidx_r;

  // Table write: append on insert, move down during the shift pass
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = didx_r - IW'(1);
    mem_wdata = mem_rdata;
    if (in_fire && (in_ch.action == ACT_INSERT) && (count_r != DEPTH_C)) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[IW-1:0];
      mem_wdata = in_entry;
    end else if ((state_r == ST_SHIFT) && dv_r) begin
      mem_we = 1'b1;
    end
  end

  rqps_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = issue ? (ptr_r + CW'(1)) : ptr_r;
    dv_nxt    = issue;
    didx_nxt  = issue ? ptr_r[IW-1:0] : didx_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt  = '0;
          stat_nxt = STAT_DONE;
          ptr_nxt  = '0;
          if (in_ch.action == ACT_INSERT) begin
            if (count_r == DEPTH_C) begin
              stat_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
            end
            state_nxt = ST_DONE;
          end else if (count_r == '0) begin
            stat_nxt  = STAT_EMPTY;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_nxt = mem_rdata;
          bidx_nxt = didx_r;
        end
        if (last_data) begin
          res_nxt   = take ? mem_rdata : best_r;
          ptr_nxt   = CW'(bidx_sel) + CW'(1);
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!issue && !dv_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      dv_r    <= dv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    didx_r <= didx_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_data_r <= res_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_proc_id = out_data_r.proc;
  assign out_ch.out_burst   = out_data_r.burst;
  assign out_ch.status      = out_stat_r;

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("ready table count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.action == ACT_INSERT) && (count_r != DEPTH_C)
    |=> count_r == ($past(count_r) + CW'(1)))
    else $error("accepted insert did not grow the table");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r != '0))
    else $error("scan started on an empty table");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && (state_r == ST_SHIFT) |-> (didx_r != '0))
    else $error("shift pass moved the head entry");

endmodule
`default_nettype wire
